### src/particle_swarm_step_macros.svh
// Assertion macros for the particle swarm step block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PARTICLE_SWARM_STEP_MACROS_SVH
`define PARTICLE_SWARM_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/pss_pkg.sv
// Package for the particle swarm step block: widths, codes, table entry types
// and the elaboration-time quarter-wave sine table. No dependencies.
package pss_pkg;

    localparam int PARTICLES    = 256;
    localparam int SINE_ENTRIES = 1024;

    localparam int ADDR_W  = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int SA_W    = $clog2(SINE_ENTRIES + 1);
    localparam int IDX_W   = 8;
    localparam int POS_W   = 26;
    localparam int POS_FRAC = 24;
    localparam int SPEED_W = 16;
    localparam int TURN_W  = 16;
    localparam int HEAD_W  = 20;
    localparam int QTR_W   = 18;
    localparam int SCR_W   = 13;
    localparam int PIX_W   = 14;
    localparam int SINE_W  = 16;
    localparam int TRIG_W  = SINE_W + 1;
    localparam int TRIG_FRAC = 15;
    localparam int PROD_W  = TRIG_W + SPEED_W + 1;
    localparam int SQ_W    = 2 * POS_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int WX_W    = POS_W + SCR_W + 1;
    localparam int PX_W    = PIX_W + 3;
    localparam int SCL_W   = QTR_W + SA_W;

    localparam int PIX_MAX = 2 ** (PIX_W - 1) - 1;
    localparam int PIX_MIN = -(2 ** (PIX_W - 1));

    localparam logic [HEAD_W-1:0] QUARTER    = HEAD_W'(1) << QTR_W;
    localparam logic [SUM_W-1:0]  UNIT_SQ    = SUM_W'(1) << (2 * POS_FRAC);
    localparam logic [WX_W-1:0]   TRUNC_BIAS = (WX_W'(1) << POS_FRAC) - WX_W'(1);

    localparam logic [SCR_W-1:0] WIDTH_RESET  = SCR_W'(800);
    localparam logic [SCR_W-1:0] HEIGHT_RESET = SCR_W'(600);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TWO_N  = 64'(2 * SINE_ENTRIES);

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } t_pos_entry;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [TURN_W-1:0]  turn;
        logic [HEAD_W-1:0]  heading;
    } t_par_entry;

    typedef logic [SINE_W-1:0] t_sine_rom [SINE_ENTRIES+1];

    // Quarter-wave entry: 2^15 * sin(pi/2 * i / SINE_ENTRIES), Q30 Taylor series.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (PI_Q30 * 64'(i)) / TWO_N;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 12; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            unique case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                9:       term = term / 64'd342;
                10:      term = term / 64'd420;
                11:      term = term / 64'd506;
                12:      term = term / 64'd600;
                default: term = term;
            endcase
            if ((k % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        r = ($unsigned(sum) + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return SINE_W'(r);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int j = 0; j <= SINE_ENTRIES; j++) begin
            rom[j] = quarter_sine(j);
        end
        return rom;
    endfunction

endpackage

### src/particle_swarm_step.sv
// Particle swarm step: particle table in two synchronous memories, fixed-point move,
// unit-circle reset, heading advance and screen pixel. Uses pss_pkg and
// particle_swarm_step_macros.svh.
//
//   channel  direction  handshake                    payload
//   in       input      i_in_valid / o_in_stall      opcode, index, speed, turn, heading
//   out      output     o_out_valid / i_out_stall    index, position, pixel, on_screen
//   cfg      input      i_cfg_we (always taken)      i_cfg_index, i_cfg_data
//
// A step item passes the trig, multiply, add, square, compare, pixel and output states
// before the next item can be taken; a load item or an index beyond the table passes the
// pixel and output states only. The input is stalled while an item is in flight; the
// finished word waits in the output register, so an item may be accepted while the
// previous word is still stalled. Positions read as zero after reset through
// per-particle valid bits; no clearing pass.
`include "particle_swarm_step_macros.svh"

module particle_swarm_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [pss_pkg::IDX_W-1:0]           i_particle_index,
    input  logic [pss_pkg::SPEED_W-1:0]         i_speed_value,
    input  logic [pss_pkg::TURN_W-1:0]          i_turn_rate,
    input  logic [pss_pkg::HEAD_W-1:0]          i_start_heading,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pss_pkg::IDX_W-1:0]           o_result_index,
    output logic signed [pss_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [pss_pkg::POS_W-1:0]    o_pos_y,
    output logic signed [pss_pkg::PIX_W-1:0]    o_pixel_x,
    output logic signed [pss_pkg::PIX_W-1:0]    o_pixel_y,
    output logic                                o_on_screen,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_index,
    input  logic [pss_pkg::SCR_W-1:0]           i_cfg_data
);

    localparam int ADDR_W    = pss_pkg::ADDR_W;
    localparam int SA_W      = pss_pkg::SA_W;
    localparam int POS_W     = pss_pkg::POS_W;
    localparam int HEAD_W    = pss_pkg::HEAD_W;
    localparam int QTR_W     = pss_pkg::QTR_W;
    localparam int SCL_W     = pss_pkg::SCL_W;
    localparam int SINE_W    = pss_pkg::SINE_W;
    localparam int TRIG_W    = pss_pkg::TRIG_W;
    localparam int PROD_W    = pss_pkg::PROD_W;
    localparam int SQ_W      = pss_pkg::SQ_W;
    localparam int WX_W      = pss_pkg::WX_W;
    localparam int PX_W      = pss_pkg::PX_W;
    localparam int PIX_W     = pss_pkg::PIX_W;
    localparam int SCR_W     = pss_pkg::SCR_W;
    localparam int PARTICLES = pss_pkg::PARTICLES;

    localparam pss_pkg::t_sine_rom SINE_ROM = pss_pkg::build_sine_rom();

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_TRIG = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_ADD  = 8'b0000_1000,
        S_SQR  = 8'b0001_0000,
        S_CMP  = 8'b0010_0000,
        S_PIX  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    pss_pkg::t_pos_entry mem_pos [PARTICLES];
    pss_pkg::t_par_entry mem_par [PARTICLES];
    logic [PARTICLES-1:0] r_pos_valid;

    logic [SCR_W-1:0] r_screen_width;
    logic [SCR_W-1:0] r_screen_height;
    logic             r_out_valid;

    logic [pss_pkg::IDX_W-1:0] r_idx;
    logic [ADDR_W-1:0]         r_addr;
    pss_pkg::t_pos_entry       r_rd_pos;
    pss_pkg::t_par_entry       r_rd_par;
    logic                      r_rd_valid;
    logic signed [POS_W-1:0]   r_x;
    logic signed [POS_W-1:0]   r_y;
    logic [HEAD_W-1:0]         r_head_new;
    logic [SINE_W-1:0]         r_cos_mag;
    logic [SINE_W-1:0]         r_sin_mag;
    logic                      r_cos_neg;
    logic                      r_sin_neg;
    logic signed [PROD_W-1:0]  r_dx;
    logic signed [PROD_W-1:0]  r_dy;
    logic [SQ_W-1:0]           r_xx;
    logic [SQ_W-1:0]           r_yy;
    logic signed [WX_W-1:0]    r_wx;
    logic signed [WX_W-1:0]    r_wy;

    logic [pss_pkg::IDX_W-1:0] r_out_index;
    logic signed [POS_W-1:0]   r_out_x;
    logic signed [POS_W-1:0]   r_out_y;
    logic signed [PIX_W-1:0]   r_out_px;
    logic signed [PIX_W-1:0]   r_out_py;
    logic                      r_out_on;

    logic                    in_accept;
    logic                    in_range;
    logic [ADDR_W-1:0]       in_addr;
    logic                    out_take;
    logic [HEAD_W-1:0]       head_cos;
    logic                    far;
    logic signed [POS_W-1:0] fin_x;
    logic signed [POS_W-1:0] fin_y;
    logic                    pos_we;
    logic [ADDR_W-1:0]       pos_waddr;
    pss_pkg::t_pos_entry     pos_wdata;
    logic                    par_we;
    logic [ADDR_W-1:0]       par_waddr;
    pss_pkg::t_par_entry     par_wdata;
    logic signed [WX_W-1:0]  adj_x;
    logic signed [WX_W-1:0]  adj_y;
    logic signed [PX_W-1:0]  pix_x;
    logic signed [PX_W-1:0]  pix_y;
    logic signed [PX_W-1:0]  lim_w;
    logic signed [PX_W-1:0]  lim_h;
    logic                    on_scr;

    function automatic logic [SA_W-1:0] sine_addr(input logic [HEAD_W-1:0] h);
        logic [SCL_W-1:0] scaled;
        logic [SA_W-1:0]  i;
        scaled = SCL_W'(h[QTR_W-1:0]) * SCL_W'(pss_pkg::SINE_ENTRIES);
        i      = scaled[SCL_W-1:QTR_W];
        return h[QTR_W] ? (SA_W'(pss_pkg::SINE_ENTRIES) - i) : i;
    endfunction

    function automatic logic signed [TRIG_W-1:0] to_trig(input logic [SINE_W-1:0] mag,
                                                         input logic neg);
        logic signed [TRIG_W-1:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [PX_W-1:0] v);
        if (v > PX_W'(pss_pkg::PIX_MAX)) begin
            return PIX_W'(pss_pkg::PIX_MAX);
        end else if (v < PX_W'(pss_pkg::PIX_MIN)) begin
            return PIX_W'(pss_pkg::PIX_MIN);
        end
        return $signed(v[PIX_W-1:0]);
    endfunction

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_range    = ({{(32 - pss_pkg::IDX_W){1'b0}}, i_particle_index} < 32'(PARTICLES));
    assign in_addr     = ADDR_W'(i_particle_index);
    assign out_take    = !r_out_valid || !i_out_stall;
    assign head_cos    = r_rd_par.heading + pss_pkg::QUARTER;

    assign far   = ({1'b0, r_xx} + {1'b0, r_yy}) > pss_pkg::UNIT_SQ;
    assign fin_x = far ? '0 : r_x;
    assign fin_y = far ? '0 : r_y;

    assign adj_x = r_wx + (r_wx[WX_W-1] ? $signed(pss_pkg::TRUNC_BIAS) : '0);
    assign adj_y = r_wy + (r_wy[WX_W-1] ? $signed(pss_pkg::TRUNC_BIAS) : '0);
    assign pix_x = PX_W'(adj_x >>> pss_pkg::POS_FRAC) + $signed(PX_W'(r_screen_width >> 1));
    assign pix_y = PX_W'(adj_y >>> pss_pkg::POS_FRAC) + $signed(PX_W'(r_screen_height >> 1));
    assign lim_w = $signed(PX_W'(r_screen_width));
    assign lim_h = $signed(PX_W'(r_screen_height));
    assign on_scr = !pix_x[PX_W-1] && !pix_y[PX_W-1] && (pix_x < lim_w) && (pix_y < lim_h);

    always_comb begin
        pos_we    = 1'b0;
        par_we    = 1'b0;
        pos_waddr = in_addr;
        par_waddr = in_addr;
        pos_wdata = '{x: '0, y: '0};
        par_wdata = '{speed: i_speed_value, turn: i_turn_rate, heading: i_start_heading};
        priority if (in_accept && in_range && (i_opcode == pss_pkg::OP_LOAD)) begin
            pos_we = 1'b1;
            par_we = 1'b1;
        end else if (r_state == S_CMP) begin
            pos_we    = 1'b1;
            par_we    = 1'b1;
            pos_waddr = r_addr;
            par_waddr = r_addr;
            pos_wdata = '{x: fin_x, y: fin_y};
            par_wdata = '{speed: r_rd_par.speed, turn: r_rd_par.turn, heading: r_head_new};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (in_range && (i_opcode == pss_pkg::OP_STEP)) ? S_TRIG : S_PIX;
                end
            end
            S_TRIG: n_state = S_MUL;
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = S_SQR;
            S_SQR:  n_state = S_CMP;
            S_CMP:  n_state = S_PIX;
            S_PIX:  n_state = S_OUT;
            S_OUT: begin
                if (out_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_pos_valid     <= '0;
            r_screen_width  <= pss_pkg::WIDTH_RESET;
            r_screen_height <= pss_pkg::HEIGHT_RESET;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && out_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (pos_we) begin
                r_pos_valid[pos_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pss_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                    pss_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            mem_pos[pos_waddr] <= pos_wdata;
        end
        if (par_we) begin
            mem_par[par_waddr] <= par_wdata;
        end
        if (in_accept) begin
            r_rd_pos   <= mem_pos[in_addr];
            r_rd_par   <= mem_par[in_addr];
            r_rd_valid <= r_pos_valid[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_idx  <= i_particle_index;
            r_addr <= in_addr;
            r_x    <= '0;
            r_y    <= '0;
        end
        unique case (r_state)
            S_TRIG: begin
                r_x        <= r_rd_valid ? r_rd_pos.x : '0;
                r_y        <= r_rd_valid ? r_rd_pos.y : '0;
                r_cos_mag  <= SINE_ROM[sine_addr(head_cos)];
                r_sin_mag  <= SINE_ROM[sine_addr(r_rd_par.heading)];
                r_cos_neg  <= head_cos[HEAD_W-1];
                r_sin_neg  <= r_rd_par.heading[HEAD_W-1];
                r_head_new <= r_rd_par.heading + HEAD_W'(r_rd_par.turn);
            end
            S_MUL: begin
                r_dx <= PROD_W'(to_trig(r_cos_mag, r_cos_neg))
                        * PROD_W'($signed({1'b0, r_rd_par.speed}));
                r_dy <= PROD_W'(to_trig(r_sin_mag, r_sin_neg))
                        * PROD_W'($signed({1'b0, r_rd_par.speed}));
            end
            S_ADD: begin
                r_x <= r_x + POS_W'(r_dx >>> pss_pkg::TRIG_FRAC);
                r_y <= r_y + POS_W'(r_dy >>> pss_pkg::TRIG_FRAC);
            end
            S_SQR: begin
                r_xx <= $unsigned(SQ_W'(r_x) * SQ_W'(r_x));
                r_yy <= $unsigned(SQ_W'(r_y) * SQ_W'(r_y));
            end
            S_CMP: begin
                r_x <= fin_x;
                r_y <= fin_y;
            end
            S_PIX: begin
                r_wx <= WX_W'($signed({1'b0, r_screen_width})) * WX_W'(r_x);
                r_wy <= WX_W'($signed({1'b0, r_screen_width})) * WX_W'(r_y);
            end
            S_OUT: begin
                if (out_take) begin
                    r_out_index <= r_idx;
                    r_out_x     <= r_x;
                    r_out_y     <= r_y;
                    r_out_px    <= sat_pix(pix_x);
                    r_out_py    <= sat_pix(pix_y);
                    r_out_on    <= on_scr;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_pos_x        = r_out_x;
    assign o_pos_y        = r_out_y;
    assign o_pixel_x      = r_out_px;
    assign o_pixel_y      = r_out_py;
    assign o_on_screen    = r_out_on;

    `PSS_ASSERT_NXT(a_step_reads_trig, i_clk, i_rst_n,
        in_accept && in_range && (i_opcode == pss_pkg::OP_STEP), r_state == S_TRIG,
        "accepted step did not start the trig lookup")
    `PSS_ASSERT_NXT(a_write_sets_valid, i_clk, i_rst_n,
        pos_we, r_pos_valid[$past(pos_waddr)],
        "position write did not mark the particle valid")
    `PSS_ASSERT_NXT(a_cmp_keeps_or_clears, i_clk, i_rst_n,
        r_state == S_CMP,
        ((r_x == $past(r_x)) && (r_y == $past(r_y))) || ((r_x == '0) && (r_y == '0)),
        "circle test altered the position other than by clearing it")
    `PSS_ASSERT_IMP(a_out_from_seq, i_clk, i_rst_n,
        $rose(r_out_valid), $past(r_state == S_OUT),
        "output word appeared outside the output state")

endmodule
